[hw/rtl/mte_pkg.sv]
package mte_pkg;

    localparam int MAX_SYMS = 8;
    localparam int IDX_W    = $clog2(MAX_SYMS);
    localparam int CNT_W    = $clog2(MAX_SYMS + 1);
    localparam int PAT_MAX  = 6;
    localparam int LEN_W    = $clog2(PAT_MAX + 1);
    localparam int NUM_PATS = 39;
    localparam int PIDX_W   = $clog2(NUM_PATS);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        SYM_DOT  = 2'd0,
        SYM_DASH = 2'd1,
        SYM_GAP  = 2'd2
    } sym_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [PAT_MAX-1:0] dash;
    } pat_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        logic [MAX_SYMS-1:0][1:0]    syms;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    localparam pat_t PAT_TABLE [NUM_PATS] = '{
        '{3'd2, 6'b000010}, '{3'd4, 6'b000001}, '{3'd4, 6'b000101},
        '{3'd3, 6'b000001}, '{3'd1, 6'b000000}, '{3'd4, 6'b000100},
        '{3'd3, 6'b000011}, '{3'd4, 6'b000000}, '{3'd2, 6'b000000},
        '{3'd4, 6'b001110}, '{3'd3, 6'b000101}, '{3'd4, 6'b000010},
        '{3'd2, 6'b000011}, '{3'd2, 6'b000001}, '{3'd3, 6'b000111},
        '{3'd4, 6'b000110}, '{3'd4, 6'b001011}, '{3'd3, 6'b000010},
        '{3'd3, 6'b000000}, '{3'd1, 6'b000001}, '{3'd3, 6'b000100},
        '{3'd4, 6'b001000}, '{3'd3, 6'b000110}, '{3'd4, 6'b001001},
        '{3'd4, 6'b001101}, '{3'd4, 6'b000011},
        '{3'd5, 6'b011111}, '{3'd5, 6'b011110}, '{3'd5, 6'b011100},
        '{3'd5, 6'b011000}, '{3'd5, 6'b010000}, '{3'd5, 6'b000000},
        '{3'd5, 6'b000001}, '{3'd5, 6'b000011}, '{3'd5, 6'b000111},
        '{3'd5, 6'b001111},
        '{3'd6, 6'b101010}, '{3'd6, 6'b110011}, '{3'd6, 6'b001100}
    };

    // Maps a character to its pattern index; found is low for unsupported codes.
    function automatic logic [PIDX_W:0] lookup_char(input logic [7:0] c);
        logic [PIDX_W:0] r;
        r = '0;
        case (c) inside
            [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61)};
            [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
            [8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd26)};
            8'h2E:         r = {1'b1, 6'd36};
            8'h2C:         r = {1'b1, 6'd37};
            8'h3F:         r = {1'b1, 6'd38};
            default:       r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mte_char_if.sv]
interface mte_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

[hw/rtl/mte_sym_if.sv]
interface mte_sym_if;
    logic       valid;
    logic       ready;
    logic [1:0] symbol;
    logic       last_in_run;

    modport source (output valid, output symbol, output last_in_run, input ready);
    modport sink   (input valid, input symbol, input last_in_run, output ready);
endinterface

[hw/rtl/mte_front.sv]
module mte_front
    import mte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mte_char_if.sink   char_in,
    input  q_stat_t    q_stat,
    output logic       push,
    output job_t       push_job
);

    logic                wrote_letter_reg;
    logic                wrote_letter_next;
    logic                word_gap_pending_reg;
    logic                word_gap_pending_next;
    logic                accept;
    logic [PIDX_W:0]     hit;
    pat_t                pat;
    logic [1:0]          lead;
    logic [LEN_W-1:0]    len;
    logic [MAX_SYMS-1:0] dash_ext;
    logic [IDX_W:0]      k;

    assign char_in.ready = !q_stat.full;
    assign accept        = char_in.valid && char_in.ready;

    always_comb
    begin
        hit                   = lookup_char(char_in.char_code);
        pat                   = PAT_TABLE[hit[PIDX_W-1:0]];
        lead                  = 2'd0;
        len                   = '0;
        wrote_letter_next     = wrote_letter_reg;
        word_gap_pending_next = word_gap_pending_reg;
        if (char_in.end_marker)
        begin
            lead                  = wrote_letter_reg ? 2'd3 : 2'd0;
            wrote_letter_next     = 1'b0;
            word_gap_pending_next = 1'b0;
        end
        else if (char_in.char_code == CHAR_SPACE)
        begin
            if (wrote_letter_reg)
            begin
                word_gap_pending_next = 1'b1;
            end
        end
        else if (hit[PIDX_W])
        begin
            if (wrote_letter_reg)
            begin
                lead = word_gap_pending_reg ? 2'd2 : 2'd1;
            end
            len                   = pat.len;
            wrote_letter_next     = 1'b1;
            word_gap_pending_next = 1'b0;
        end
        dash_ext       = {(MAX_SYMS - PAT_MAX)'(0), pat.dash};
        push_job.count = CNT_W'(lead) + CNT_W'(len);
        for (int p = 0; p < MAX_SYMS; p++)
        begin
            k = (IDX_W + 1)'(p) - (IDX_W + 1)'(lead);
            if (p < int'(lead))
            begin
                push_job.syms[p] = SYM_GAP;
            end
            else if (k < (IDX_W + 1)'(len))
            begin
                push_job.syms[p] = dash_ext[k[IDX_W-1:0]] ? SYM_DASH : SYM_DOT;
            end
            else
            begin
                push_job.syms[p] = SYM_DOT;
            end
        end
        push = accept && (push_job.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrote_letter_reg     <= 1'b0;
            word_gap_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            wrote_letter_reg     <= wrote_letter_next;
            word_gap_pending_reg <= word_gap_pending_next;
        end
    end

    // A pending word gap only exists after something was written.
    a_gap_needs_letter: assert property (@(posedge clk) disable iff (!rst_n)
        word_gap_pending_reg |-> wrote_letter_reg)
        else $error("word gap pending with nothing written");

endmodule

[hw/rtl/mte_queue.sv]
module mte_queue
    import mte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t q_stat
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full && !pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("pop from an empty queue");

endmodule

[hw/rtl/mte_back.sv]
module mte_back
    import mte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head_job,
    input  q_stat_t   q_stat,
    output logic      pop,
    mte_sym_if.source sym_out
);

    logic             valid_reg;
    logic [1:0]       symbol_reg;
    logic             last_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             advance;
    logic             emit;
    logic             at_last;

    assign advance = !valid_reg || sym_out.ready;
    assign emit    = advance && !q_stat.empty;
    assign at_last = (CNT_W'(idx_reg) == head_job.count - 1'b1);
    assign pop     = emit && at_last;

    assign sym_out.valid       = valid_reg;
    assign sym_out.symbol      = symbol_reg;
    assign sym_out.last_in_run = last_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            symbol_reg <= head_job.syms[idx_reg];
            last_reg   <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= emit;
            if (emit)
            begin
                idx_reg <= at_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    // While a job is queued, the running index points inside the job at the queue head.
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> (CNT_W'(idx_reg) < head_job.count))
        else $error("symbol index beyond job length");

    a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0))
        else $error("index not restarted after last symbol");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> (idx_reg == '0))
        else $error("index moved while no job is queued");

endmodule

[hw/rtl/morse_text_encoder.sv]
// Channel   Role    Payload
// char_in   sink    char_code[7:0], end_marker
// sym_out   source  symbol[1:0], last_in_run
//
// Each supported character, and an end marker after text, becomes one queued job of up to
// eight symbols, sent one per cycle while sym_out is ready, by the symbol serializer.
// Items that give no symbols are taken as long as the two-entry job queue has room.
// char_in stalls only when the job queue is full; sym_out stalls hold the output register.
// Reset clears the letter and word gap flags, empties the queue and clears the output valid flag.
module morse_text_encoder
    import mte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mte_char_if.sink  char_in,
    mte_sym_if.source sym_out
);

    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;

    mte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    mte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    mte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .sym_out  (sym_out)
    );

endmodule

[bench/morse_text_encoder_test.sv]
`timescale 1ns / 1ps

module morse_text_encoder_test;
    import mte_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        sym_t symbol;
        logic is_last;
    } sym_word_t;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   errors;
    int   cycle_count;

    logic have_text;
    logic word_gap_armed;

    sym_word_t expected_syms[$];

    string morse_book[39] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----.",
        ".-.-.-", "--..--", "..--.."
    };

    mte_char_if char_bus ();
    mte_sym_if  sym_bus ();

    morse_text_encoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .sym_out (sym_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int book_index(logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (u >= "a" && u <= "z")
            u = u - 8'h20;
        if (u >= "A" && u <= "Z")
            return int'(u - "A");
        if (u >= "0" && u <= "9")
            return int'(u - "0") + 26;
        if (u == ".")
            return 36;
        if (u == ",")
            return 37;
        if (u == "?")
            return 38;
        return -1;
    endfunction

    function automatic void push_sym(sym_t s);
        sym_word_t w;
        w.symbol  = s;
        w.is_last = 1'b0;
        expected_syms.push_back(w);
    endfunction

    function automatic void predict_symbols(logic [7:0] c, logic fin);
        int    idx;
        int    n;
        string pat;
        n = 0;
        if (fin)
        begin
            if (have_text)
            begin
                repeat (3)
                begin
                    push_sym(SYM_GAP);
                    n++;
                end
            end
            have_text      = 1'b0;
            word_gap_armed = 1'b0;
        end
        else if (c == CHAR_SPACE)
        begin
            if (have_text)
                word_gap_armed = 1'b1;
        end
        else
        begin
            idx = book_index(c);
            if (idx >= 0)
            begin
                pat = morse_book[idx];
                if (have_text)
                begin
                    push_sym(SYM_GAP);
                    n++;
                    if (word_gap_armed)
                    begin
                        push_sym(SYM_GAP);
                        n++;
                    end
                end
                word_gap_armed = 1'b0;
                for (int i = 0; i < pat.len(); i++)
                begin
                    push_sym(pat[i] == "-" ? SYM_DASH : SYM_DOT);
                    n++;
                end
                have_text = 1'b1;
            end
        end
        if (n > 0)
            expected_syms[expected_syms.size() - 1].is_last = 1'b1;
    endfunction

    task automatic send_word(logic [7:0] c, logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            char_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        char_bus.valid      <= 1'b1;
        char_bus.char_code  <= c;
        char_bus.end_marker <= fin;
        do
            @(posedge clk);
        while (!char_bus.ready);
        predict_symbols(c, fin);
    endtask

    function automatic logic [7:0] random_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            return 8'($urandom_range("A", "Z"));
        if (r < 56)
            return 8'($urandom_range("a", "z"));
        if (r < 70)
            return 8'($urandom_range("0", "9"));
        if (r < 73)
            return ".";
        if (r < 76)
            return ",";
        if (r < 79)
            return "?";
        if (r < 91)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_directed_text();
        send_word("A", 1'b1);
        send_word(CHAR_SPACE, 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word("E", 1'b0);
        send_word("z", 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word("0", 1'b0);
        send_word("9", 1'b0);
        send_word(".", 1'b0);
        send_word(",", 1'b0);
        send_word("?", 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("@", 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word("q", 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        send_word("Y", 1'b0);
        send_word("T", 1'b0);
        send_word(CHAR_SPACE, 1'b0);
        send_word(8'h20, 1'b1);
    endtask

    task automatic test_random_messages(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len && sent < items; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_word(8'($urandom_range(0, 255)), 1'b1);
                else
                    send_word(random_text_char(), 1'b0);
                sent++;
            end
            if (sent < items && $urandom_range(0, 7) != 0)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
                sent++;
            end
        end
    endtask

    task automatic finish_run();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (expected_syms.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** morse_text_encoder: PASSED **");
        else
            $display("** morse_text_encoder: FAILED **");
        $finish;
    endtask

    initial
    begin
        int stall_left;
        sym_bus.ready = 1'b0;
        stall_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                sym_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                sym_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sym_word_t exp_word;
        if (rst_n && sym_bus.valid && sym_bus.ready)
        begin
            if (expected_syms.size() == 0)
            begin
                $display("%0t: unexpected symbol: expected none, actual %0d/%0b", $time,
                    sym_bus.symbol, sym_bus.last_in_run);
                errors++;
            end
            else
            begin
                exp_word = expected_syms.pop_front();
                if (sym_bus.symbol !== exp_word.symbol)
                begin
                    $display("%0t: symbol mismatch: expected %0d, actual %0d", $time,
                        exp_word.symbol, sym_bus.symbol);
                    errors++;
                end
                if (sym_bus.last_in_run !== exp_word.is_last)
                begin
                    $display("%0t: last_in_run mismatch: expected %0b, actual %0b", $time,
                        exp_word.is_last, sym_bus.last_in_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d symbols outstanding", $time, expected_syms.size());
            $display("** morse_text_encoder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        errors              = 0;
        cycle_count         = 0;
        have_text           = 1'b0;
        word_gap_armed      = 1'b0;
        char_bus.valid      = 1'b0;
        char_bus.char_code  = 8'h00;
        char_bus.end_marker = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_text();
        test_random_messages(260);
        // Back-to-back traffic on both sides to close the run.
        idle_on = 1'b0;
        test_random_messages(60);
        finish_run();
    end

endmodule
